@@ rtl/core/bmp24_to_rgb565_stream_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the BMP to RGB565 stream converter
// Clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef BMP24_TO_RGB565_STREAM_TOP_MACROS_SVH
`define BMP24_TO_RGB565_STREAM_TOP_MACROS_SVH

// A property that must hold at every clock edge.
`define BMP565_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition at one edge that implies another at the next edge.
`define BMP565_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bmp565_pkg.sv @@
// ---------------------------------------------------------------------------
// bmp565_pkg
// Types, codes and helpers shared by the BMP to RGB565 stream converter.
// ---------------------------------------------------------------------------
package bmp565_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_BMP   = 2'd1;
  localparam logic [1:0] ST_FORMAT    = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 1'b1;

  // Header layout: first byte position of each captured field, and the last header byte.
  localparam logic [5:0] HDR_SIG    = 6'd0;
  localparam logic [5:0] HDR_OFFSET = 6'd10;
  localparam logic [5:0] HDR_WIDTH  = 6'd18;
  localparam logic [5:0] HDR_HEIGHT = 6'd22;
  localparam logic [5:0] HDR_PLANES = 6'd26;
  localparam logic [5:0] HDR_BPP    = 6'd28;
  localparam logic [5:0] HDR_COMP   = 6'd30;
  localparam logic [5:0] HDR_LAST   = 6'd33;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_PLANES    = 16'd1;
  localparam logic [15:0] BMP_BPP       = 16'd24;

  // Positions within a B,G,R triple.
  localparam logic [1:0] TRIPLE_RED = 2'd2;

  typedef struct packed {
    logic restart;
    logic pix_en;
  } pix_ctl_t;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic        bottom_up;
  } geom_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } err_t;

  typedef struct packed {
    logic [15:0] pixel_word;
    logic [15:0] screen_x;
    logic [15:0] screen_y;
    logic [1:0]  status;
    logic        last_item;
  } result_t;

  // RGB565 with its two bytes swapped.
  function automatic logic [15:0] rgb565_swapped(input logic [7:0] blue,
                                                 input logic [7:0] green,
                                                 input logic [7:0] red);
    logic [15:0] w;
    w = {red[7:3], green[7:2], blue[7:3]};
    return {w[7:0], w[15:8]};
  endfunction

endpackage

@@ rtl/core/bmp565_stream_if.sv @@
// ---------------------------------------------------------------------------
// bmp565 stream interfaces
// File byte channel and pixel result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface bmp565_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, file_byte, start_of_file, input ready);
  modport sink   (input valid, file_byte, start_of_file, output ready);
endinterface

interface bmp565_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_word;
  logic [15:0] screen_x;
  logic [15:0] screen_y;
  logic [1:0]  status;
  logic        last_item;

  modport source (output valid, pixel_word, screen_x, screen_y, status, last_item,
                  input ready);
  modport sink   (input valid, pixel_word, screen_x, screen_y, status, last_item,
                  output ready);
endinterface

@@ rtl/core/bmp565_parse.sv @@
// ---------------------------------------------------------------------------
// bmp565_parse
// Byte counter, header capture, header checks and parse phase control.
// ---------------------------------------------------------------------------
module bmp565_parse #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          file_byte,
  input  logic                start_of_file,
  input  logic                at_last,
  output bmp565_pkg::pix_ctl_t ctl,
  output bmp565_pkg::geom_t    geom,
  output bmp565_pkg::err_t     err
);

  bmp565_pkg::phase_t phase, phase_eff, phase_next;
  logic [31:0] byte_index, idx_eff, byte_index_next;
  logic [5:0]  idx6;

  logic [15:0] hdr_sig;
  logic [31:0] hdr_offset;
  logic [31:0] hdr_width;
  logic [31:0] hdr_height;
  logic [15:0] hdr_planes;
  logic [15:0] hdr_bpp;
  logic [23:0] hdr_comp;
  logic [31:0] height_mag;

  logic hdr_done, sig_bad, fmt_bad, size_bad, empty_img, before_pixels;

  // A start mark restarts parsing with the marked byte as byte 0.
  assign phase_eff       = start_of_file ? bmp565_pkg::PH_HEADER : phase;
  assign idx_eff         = start_of_file ? 32'd0 : byte_index;
  assign idx6            = idx_eff[5:0];
  assign byte_index_next = (&idx_eff) ? idx_eff : idx_eff + 32'd1;

  assign height_mag    = hdr_height[31] ? (32'd0 - hdr_height) : hdr_height;
  assign hdr_done      = (idx6 == bmp565_pkg::HDR_LAST);
  assign sig_bad       = (hdr_sig != bmp565_pkg::BMP_SIGNATURE);
  // The top byte of the compression field is the byte arriving now.
  assign fmt_bad       = (hdr_planes != bmp565_pkg::BMP_PLANES) ||
                         (hdr_bpp != bmp565_pkg::BMP_BPP) ||
                         ({file_byte, hdr_comp} != 32'd0);
  assign size_bad      = (hdr_width > 32'(MAX_WIDTH)) || (height_mag > 32'(MAX_HEIGHT));
  assign empty_img     = (hdr_width == 32'd0) || (height_mag == 32'd0);
  assign before_pixels = (idx_eff < hdr_offset);

  assign geom.width     = hdr_width[15:0];
  assign geom.height    = height_mag[15:0];
  assign geom.bottom_up = ~hdr_height[31];

  always_comb begin
    phase_next = phase_eff;
    unique case (phase_eff)
      bmp565_pkg::PH_HEADER: begin
        if (hdr_done) begin
          if (sig_bad || fmt_bad || size_bad || empty_img) begin
            phase_next = bmp565_pkg::PH_IDLE;
          end else begin
            phase_next = bmp565_pkg::PH_SKIP;
          end
        end
      end
      bmp565_pkg::PH_SKIP: begin
        if (!before_pixels) begin
          phase_next = at_last ? bmp565_pkg::PH_IDLE : bmp565_pkg::PH_PIXELS;
        end
      end
      bmp565_pkg::PH_PIXELS: begin
        if (at_last) begin
          phase_next = bmp565_pkg::PH_IDLE;
        end
      end
      bmp565_pkg::PH_IDLE: begin
        phase_next = bmp565_pkg::PH_IDLE;
      end
      default: begin
        phase_next = bmp565_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.restart = step && start_of_file;
    ctl.pix_en  = 1'b0;
    err.valid   = 1'b0;
    err.code    = bmp565_pkg::ST_OK;
    unique case (phase_eff)
      bmp565_pkg::PH_HEADER: begin
        err.valid = step && hdr_done && (sig_bad || fmt_bad || size_bad);
        priority if (sig_bad) begin
          err.code = bmp565_pkg::ST_NOT_BMP;
        end else if (fmt_bad) begin
          err.code = bmp565_pkg::ST_FORMAT;
        end else begin
          err.code = bmp565_pkg::ST_TOO_LARGE;
        end
      end
      bmp565_pkg::PH_SKIP: begin
        ctl.pix_en = step && !before_pixels;
      end
      bmp565_pkg::PH_PIXELS: begin
        ctl.pix_en = step;
      end
      default: begin
        ctl.pix_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= bmp565_pkg::PH_HEADER;
      byte_index <= 32'd0;
    end else if (step) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
    end
  end

  // Each captured header field byte is written once per file before the checks read it.
  always_ff @(posedge clk) begin
    if (step && phase_eff == bmp565_pkg::PH_HEADER) begin
      if (idx6 < bmp565_pkg::HDR_SIG + 6'd2) begin
        hdr_sig[{idx6[0], 3'b000} +: 8] <= file_byte;
      end
      if (idx6 >= bmp565_pkg::HDR_OFFSET && idx6 < bmp565_pkg::HDR_OFFSET + 6'd4) begin
        hdr_offset[{2'(idx6 - bmp565_pkg::HDR_OFFSET), 3'b000} +: 8] <= file_byte;
      end
      if (idx6 >= bmp565_pkg::HDR_WIDTH && idx6 < bmp565_pkg::HDR_WIDTH + 6'd4) begin
        hdr_width[{2'(idx6 - bmp565_pkg::HDR_WIDTH), 3'b000} +: 8] <= file_byte;
      end
      if (idx6 >= bmp565_pkg::HDR_HEIGHT && idx6 < bmp565_pkg::HDR_HEIGHT + 6'd4) begin
        hdr_height[{2'(idx6 - bmp565_pkg::HDR_HEIGHT), 3'b000} +: 8] <= file_byte;
      end
      if (idx6 >= bmp565_pkg::HDR_PLANES && idx6 < bmp565_pkg::HDR_PLANES + 6'd2) begin
        hdr_planes[{idx6[0], 3'b000} +: 8] <= file_byte;
      end
      if (idx6 >= bmp565_pkg::HDR_BPP && idx6 < bmp565_pkg::HDR_BPP + 6'd2) begin
        hdr_bpp[{idx6[0], 3'b000} +: 8] <= file_byte;
      end
      if (idx6 >= bmp565_pkg::HDR_COMP && idx6 < bmp565_pkg::HDR_LAST) begin
        hdr_comp[{2'(idx6 - bmp565_pkg::HDR_COMP), 3'b000} +: 8] <= file_byte;
      end
    end
  end

endmodule

@@ rtl/core/bmp565_pixel.sv @@
// ---------------------------------------------------------------------------
// bmp565_pixel
// Triple assembly, row padding skip, column and row counting, pixel output.
// ---------------------------------------------------------------------------
module bmp565_pixel #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bmp565_pkg::pix_ctl_t ctl,
  input  bmp565_pkg::geom_t    geom,
  input  logic [7:0]           file_byte,
  input  logic [15:0]          x_origin,
  input  logic [15:0]          y_origin,
  output logic                 at_last,
  output logic                 pix_valid,
  output bmp565_pkg::result_t  pix_res
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [1:0]    triple_phase;
  logic [1:0]    pad_count;
  logic [15:0]   held_blue_green;
  logic          col_last, row_last, red_byte;
  logic [15:0]   disp_row;

  assign col_last = (column_count + CW'(1)) == geom.width[CW-1:0];
  assign row_last = (row_count + RW'(1)) == geom.height[RW-1:0];
  assign red_byte = (pad_count == 2'd0) && (triple_phase == bmp565_pkg::TRIPLE_RED);
  assign at_last  = red_byte && col_last && row_last;

  // Bottom-up files start with the lowest screen row.
  assign disp_row = geom.bottom_up ? (geom.height - 16'(row_count) - 16'd1)
                                   : 16'(row_count);

  assign pix_valid          = ctl.pix_en && red_byte;
  assign pix_res.pixel_word = bmp565_pkg::rgb565_swapped(held_blue_green[7:0],
                                                         held_blue_green[15:8], file_byte);
  assign pix_res.screen_x   = x_origin + 16'(column_count);
  assign pix_res.screen_y   = y_origin + disp_row;
  assign pix_res.status     = bmp565_pkg::ST_OK;
  assign pix_res.last_item  = at_last;

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      column_count <= '0;
      row_count    <= '0;
      triple_phase <= 2'd0;
      pad_count    <= 2'd0;
    end else if (ctl.pix_en) begin
      if (pad_count != 2'd0) begin
        pad_count <= pad_count - 2'd1;
      end else if (triple_phase != bmp565_pkg::TRIPLE_RED) begin
        triple_phase <= triple_phase + 2'd1;
      end else begin
        triple_phase <= 2'd0;
        if (!at_last) begin
          if (col_last) begin
            column_count <= '0;
            row_count    <= row_count + RW'(1);
            pad_count    <= geom.width[1:0];
          end else begin
            column_count <= column_count + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pix_en && pad_count == 2'd0 && triple_phase != bmp565_pkg::TRIPLE_RED) begin
      held_blue_green[{triple_phase[0], 3'b000} +: 8] <= file_byte;
    end
  end

endmodule

@@ rtl/core/bmp24_to_rgb565_stream_top.sv @@
// ---------------------------------------------------------------------------
// bmp24_to_rgb565_stream_top
// Streams a 24-bit uncompressed BMP file in and RGB565 pixels out.
// ---------------------------------------------------------------------------
// Usage:
//   byte_in carries one file byte per item; start_of_file marks byte 0 of a
//   file and restarts parsing. pixel_out carries one pixel per item with its
//   screen position, or a single error item (status not zero, last_item set).
//   The item for the final pixel also has last_item set; after it, or after an
//   error, bytes are taken and dropped until the next start mark.
//   x_origin and y_origin are written through cfg_we/cfg_index/cfg_data
//   while no file is in flight.
// Timing:
//   An accepted byte is held in the input register; its result is then
//   registered in the output register and presented on pixel_out. One byte
//   is taken every cycle while pixel_out does not stall; the single
//   header/pixel update stage lies between the two registers.
// Reset and stall:
//   rst clears the parser, the origins and both valid flags.
//   When pixel_out stalls the result waits in the output register; one more
//   byte then waits in the input register and byte_in.ready falls.
// ---------------------------------------------------------------------------
`include "bmp24_to_rgb565_stream_top_macros.svh"

module bmp24_to_rgb565_stream_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bmp565_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmp565_pkg::CFG_DATA_W-1:0] cfg_data,
  bmp565_byte_if.sink                       byte_in,
  bmp565_pixel_if.source                    pixel_out
);

  logic [15:0] x_origin, y_origin;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_sof_q;

  logic                out_valid_q;
  bmp565_pkg::result_t out_q, res_next;

  logic can_load, advance, at_last, pix_valid;

  bmp565_pkg::pix_ctl_t ctl;
  bmp565_pkg::geom_t    geom;
  bmp565_pkg::err_t     err;
  bmp565_pkg::result_t  pix_res;

  assign can_load      = !out_valid_q || pixel_out.ready;
  assign advance       = in_valid_q && can_load;
  assign byte_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= 16'd0;
      y_origin <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmp565_pkg::CFG_X_ORIGIN: x_origin <= cfg_data;
        bmp565_pkg::CFG_Y_ORIGIN: y_origin <= cfg_data;
        default: x_origin <= x_origin;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte_q <= byte_in.file_byte;
      in_sof_q  <= byte_in.start_of_file;
    end
  end

  bmp565_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .file_byte     (in_byte_q),
    .start_of_file (in_sof_q),
    .at_last       (at_last),
    .ctl           (ctl),
    .geom          (geom),
    .err           (err)
  );

  bmp565_pixel #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pixel (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .geom      (geom),
    .file_byte (in_byte_q),
    .x_origin  (x_origin),
    .y_origin  (y_origin),
    .at_last   (at_last),
    .pix_valid (pix_valid),
    .pix_res   (pix_res)
  );

  always_comb begin
    if (err.valid) begin
      res_next.pixel_word = 16'd0;
      res_next.screen_x   = 16'd0;
      res_next.screen_y   = 16'd0;
      res_next.status     = err.code;
      res_next.last_item  = 1'b1;
    end else begin
      res_next = pix_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (can_load) begin
      out_valid_q <= advance && (err.valid || pix_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (err.valid || pix_valid)) begin
      out_q <= res_next;
    end
  end

  assign pixel_out.valid      = out_valid_q;
  assign pixel_out.pixel_word = out_q.pixel_word;
  assign pixel_out.screen_x   = out_q.screen_x;
  assign pixel_out.screen_y   = out_q.screen_y;
  assign pixel_out.status     = out_q.status;
  assign pixel_out.last_item  = out_q.last_item;

  `BMP565_ASSERT(a_err_pix_excl, !(err.valid && pix_valid), "error and pixel in one step")
  `BMP565_ASSERT(a_no_overrun, !(in_valid_q && !advance && byte_in.ready), "input overrun")
  `BMP565_ASSERT_NEXT(a_hold_input, in_valid_q && !can_load, in_valid_q, "stalled item lost")
  `BMP565_ASSERT(a_err_shape, !(out_valid_q && out_q.status != bmp565_pkg::ST_OK) || (out_q.last_item && out_q.pixel_word == 16'd0), "bad error item")

endmodule
